// File: rtl/core/spilcd_pkg.sv
// Shared types, constants and a helper function for the serial display pixel writer.
package spilcd_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE  = 2'd2;

    localparam logic [7:0] COLUMN_SET_RESET = 8'd42;
    localparam logic [7:0] ROW_SET_RESET    = 8'd43;
    localparam logic [7:0] MEM_WRITE_RESET  = 8'd44;

    localparam logic [2:0] COUNT_LIMIT = 3'd5;
    localparam logic [2:0] WINDOW_BYTES = 3'd4;
    localparam logic [2:0] PIXEL_BYTES  = 3'd3;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       chip_select_n;
        logic       data_not_command;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] column_set_code;
        logic [7:0] row_set_code;
        logic [7:0] memory_write_code;
    } cmd_codes_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } pixel_t;

    typedef struct packed {
        pixel_t first;
        pixel_t second;
    } pixel_pair_t;

    // A full-scale nibble maps to full scale; everything else is a plain shift.
    function automatic logic [7:0] expand_nibble(input logic [3:0] n);
        logic [7:0] v;
        v = (n == 4'hF) ? 8'hFF : {n, 4'h0};
        return v;
    endfunction

endpackage

// File: rtl/core/spi_lcd_window_pixel_writer.sv
// Top level of the serial display window and pixel writer.
// Usage:
//   Input channel (in_valid / in_stall) carries one serial byte per beat with its
//   chip-select and data/command flags. Column-set and row-set commands take four
//   data bytes (16-bit start, 16-bit end); memory-write takes three data bytes as
//   two RGB444 pixels. Output channel (out_valid / out_stall) carries one pixel
//   per beat with its position and 8-bit channels; last marks the right pixel.
//   The configuration channel (cfg_valid / cfg_ready) sets the three command codes;
//   cfg_ready is always high. The user makes writes while the block is idle; unchecked.
// Timing:
//   A byte is decoded in the input register, and the state it changes is updated
//   at the next edge. A pair's first pixel is presented once the pair completed by
//   its third byte is loaded into the result buffer; the second follows one beat
//   later. Bytes are taken one per cycle while in_stall is low; a pair needs three
//   bytes but only two output beats, so without output stalls input never waits.
// Reset clears the command, count, window and cursor and restores the default
// command codes. While out_stall is high the pending pixel holds; once the input
// register holds the third byte of a pair that cannot enter the result buffer,
// in_stall rises.
module spi_lcd_window_pixel_writer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     spi_byte,
    input  logic                           chip_select_n,
    input  logic                           data_not_command,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [15:0]                    pixel_x,
    output logic [15:0]                    pixel_y,
    output logic [7:0]                     red,
    output logic [7:0]                     green,
    output logic [7:0]                     blue,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spilcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import spilcd_pkg::*;

    byte_item_t  item_reg;
    logic        item_valid_reg, item_valid_next;
    cmd_codes_t  codes_reg, codes_next;
    logic        emit;
    logic        fire;
    logic        can_load;
    logic        pop;
    pixel_pair_t pair;
    pixel_t      pixel;

    assign cfg_ready = 1'b1;
    assign pop       = out_valid && !out_stall;
    assign fire      = item_valid_reg && (!emit || can_load);
    assign in_stall  = item_valid_reg && !fire;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && !in_stall)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end

        codes_next = codes_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COLUMN_SET: codes_next.column_set_code   = cfg_data;
                CFG_ROW_SET:    codes_next.row_set_code      = cfg_data;
                CFG_MEM_WRITE:  codes_next.memory_write_code = cfg_data;
                default:        codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg              <= 1'b0;
            codes_reg.column_set_code   <= COLUMN_SET_RESET;
            codes_reg.row_set_code      <= ROW_SET_RESET;
            codes_reg.memory_write_code <= MEM_WRITE_RESET;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            codes_reg      <= codes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.spi_byte         <= spi_byte;
            item_reg.chip_select_n    <= chip_select_n;
            item_reg.data_not_command <= data_not_command;
        end
    end

    spilcd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .fire       (fire),
        .codes      (codes_reg),
        .emit       (emit),
        .pair       (pair)
    );

    spilcd_out_buf u_out_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && emit),
        .pair     (pair),
        .pop      (pop),
        .can_load (can_load),
        .valid    (out_valid),
        .pixel    (pixel)
    );

    assign pixel_x = pixel.x;
    assign pixel_y = pixel.y;
    assign red     = pixel.red;
    assign green   = pixel.green;
    assign blue    = pixel.blue;
    assign last    = pixel.last;

endmodule

// File: rtl/core/spilcd_ctrl.sv
// Command decoder, window and cursor state, and pixel pair formation.
module spilcd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  spilcd_pkg::byte_item_t item,
    input  logic                 fire,
    input  spilcd_pkg::cmd_codes_t codes,
    output logic                 emit,
    output spilcd_pkg::pixel_pair_t pair
);
    import spilcd_pkg::*;

    logic [7:0]  cur_cmd_reg, cur_cmd_next;
    logic        cmd_valid_reg, cmd_valid_next;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  data_bytes_reg [0:2];
    logic [15:0] start_x_reg, start_x_next;
    logic [16:0] end_x_reg, end_x_next;
    logic [16:0] cursor_x_reg, cursor_x_next;
    logic [15:0] start_y_reg, start_y_next;
    logic [16:0] end_y_reg, end_y_next;
    logic [16:0] cursor_y_reg, cursor_y_next;

    logic        selected;
    logic        is_cmd_byte;
    logic        is_data_byte;
    logic [2:0]  count_inc;
    logic        is_col;
    logic        is_row;
    logic        is_mem;
    logic        win_load;
    logic        mem_done;
    logic [15:0] win_start;
    logic [16:0] win_end_p1;
    logic [16:0] cursor_x_step;
    logic [11:0] left_color;
    logic [11:0] right_color;

    always_comb
    begin
        selected     = item_valid && !item.chip_select_n;
        is_cmd_byte  = selected && !item.data_not_command;
        is_data_byte = selected && item.data_not_command && cmd_valid_reg;
        count_inc    = (count_reg < COUNT_LIMIT) ? count_reg + 3'd1 : count_reg;

        // Coinciding codes resolve column first, then row, then memory write.
        is_col = (cur_cmd_reg == codes.column_set_code);
        is_row = !is_col && (cur_cmd_reg == codes.row_set_code);
        is_mem = !is_col && !is_row && (cur_cmd_reg == codes.memory_write_code);

        win_load = is_data_byte && (is_col || is_row) && (count_inc == WINDOW_BYTES);
        mem_done = is_data_byte && is_mem && (count_inc == PIXEL_BYTES);
        emit     = mem_done && (cursor_y_reg < end_y_reg);

        win_start  = {data_bytes_reg[0], data_bytes_reg[1]};
        win_end_p1 = {1'b0, data_bytes_reg[2], item.spi_byte} + 17'd1;

        left_color  = {data_bytes_reg[0], data_bytes_reg[1][7:4]};
        right_color = {data_bytes_reg[1][3:0], item.spi_byte};
        cursor_x_step = cursor_x_reg + 17'd2;

        pair.first.x      = cursor_x_reg[15:0];
        pair.first.y      = cursor_y_reg[15:0];
        pair.first.red    = expand_nibble(left_color[11:8]);
        pair.first.green  = expand_nibble(left_color[7:4]);
        pair.first.blue   = expand_nibble(left_color[3:0]);
        pair.first.last   = 1'b0;
        pair.second.x     = cursor_x_reg[15:0] + 16'd1;
        pair.second.y     = cursor_y_reg[15:0];
        pair.second.red   = expand_nibble(right_color[11:8]);
        pair.second.green = expand_nibble(right_color[7:4]);
        pair.second.blue  = expand_nibble(right_color[3:0]);
        pair.second.last  = 1'b1;
    end

    always_comb
    begin
        cur_cmd_next   = cur_cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        count_next     = count_reg;
        start_x_next   = start_x_reg;
        end_x_next     = end_x_reg;
        cursor_x_next  = cursor_x_reg;
        start_y_next   = start_y_reg;
        end_y_next     = end_y_reg;
        cursor_y_next  = cursor_y_reg;

        if (fire && is_cmd_byte)
        begin
            // The count survives a repeat of the same command.
            if (cmd_valid_reg && (cur_cmd_reg != item.spi_byte))
            begin
                count_next = 3'd0;
            end
            cur_cmd_next   = item.spi_byte;
            cmd_valid_next = 1'b1;
        end
        else if (fire && is_data_byte)
        begin
            count_next = mem_done ? 3'd0 : count_inc;
            if (win_load && is_col)
            begin
                start_x_next  = win_start;
                end_x_next    = win_end_p1;
                cursor_x_next = {1'b0, win_start};
            end
            if (win_load && is_row)
            begin
                start_y_next  = win_start;
                end_y_next    = win_end_p1;
                cursor_y_next = {1'b0, win_start};
            end
            if (emit)
            begin
                if (cursor_x_step >= end_x_reg)
                begin
                    cursor_x_next = {1'b0, start_x_reg};
                    cursor_y_next = cursor_y_reg + 17'd1;
                end
                else
                begin
                    cursor_x_next = cursor_x_step;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_cmd_reg   <= '0;
            cmd_valid_reg <= 1'b0;
            count_reg     <= '0;
            start_x_reg   <= '0;
            end_x_reg     <= '0;
            cursor_x_reg  <= '0;
            start_y_reg   <= '0;
            end_y_reg     <= '0;
            cursor_y_reg  <= '0;
        end
        else
        begin
            cur_cmd_reg   <= cur_cmd_next;
            cmd_valid_reg <= cmd_valid_next;
            count_reg     <= count_next;
            start_x_reg   <= start_x_next;
            end_x_reg     <= end_x_next;
            cursor_x_reg  <= cursor_x_next;
            start_y_reg   <= start_y_next;
            end_y_reg     <= end_y_next;
            cursor_y_reg  <= cursor_y_next;
        end
    end

    // Only the first three data bytes are kept; the fourth is used as it arrives.
    always_ff @(posedge clk)
    begin
        if (fire && is_data_byte && (count_reg < PIXEL_BYTES))
        begin
            data_bytes_reg[count_reg[1:0]] <= item.spi_byte;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("data count above its limit");

    a_emit_needs_mem: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit) |=> (count_reg == 3'd0))
        else $error("pixel pair emitted without clearing the data count");

endmodule

// File: rtl/core/spilcd_out_buf.sv
// Two-entry result buffer that presents a pixel pair one beat at a time.
module spilcd_out_buf
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  spilcd_pkg::pixel_pair_t pair,
    input  logic                    pop,
    output logic                    can_load,
    output logic                    valid,
    output spilcd_pkg::pixel_t      pixel
);
    import spilcd_pkg::*;

    pixel_pair_t pair_reg;
    logic [1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        valid    = (cnt_reg != 2'd0);
        pixel    = (cnt_reg == 2'd2) ? pair_reg.first : pair_reg.second;
        // A new pair may land in the same cycle the final beat leaves.
        can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = 2'd2;
        end
        else if (pop && valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_reg <= pair;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop)))
        else $error("pair loaded over a beat not yet taken");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (cnt_reg == 2'd2))
        else $error("loaded pair not presented in full");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

endmodule
